>>> sv/bir_pkg.sv
`default_nettype none
package bir_pkg;

  localparam int SRC_W      = 9;
  localparam int DST_W      = 13;
  localparam int COORD_W    = 12;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_SRC_WIDTH_D  = 256;
  localparam int MAX_SRC_HEIGHT_D = 256;
  localparam int FRACTION_BITS_D  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  localparam logic [SRC_W-1:0] SRC_SIZE_RST = 9'd256;
  localparam logic [DST_W-1:0] DST_SIZE_RST = 13'd256;

  typedef struct packed {
    logic             we;
    logic [PIX_W-1:0] wdata;
  } ram_wr_t;

endpackage
`default_nettype wire

>>> sv/bilinear_image_resize.sv
`default_nettype none
// Bilinear RGB image scaler.
// Input channel: an item is taken when start is high and busy is low; busy
// stays low, so one item may be transferred every cycle. in_command low
// loads in_red/in_green/in_blue into the next image store entry (raster
// order); high requests destination pixel (in_dest_x, in_dest_y).
// Config channel: cfg_ready is always high; a write to a size register sets
// it and restarts the load address. Write only while the block is idle.
// Results: one per request, shown for one cycle with out_valid high. The
// receiver cannot stall; no results are produced for loads.
// Pipeline: entry stage, then the pipelined divider, one stage per quotient
// bit, followed by clamp, address, store read, three blend stages and the
// output register.
// Throughput: one item per cycle; the store is held in two copies, each
// with two read ports, so all four neighbours are fetched at once.
// Reset: size registers return to 256, load address to zero, pipeline
// emptied. The image store is not cleared.
module bilinear_image_resize #(
  parameter int MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH_D,
  parameter int MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT_D,
  parameter int FRACTION_BITS  = bir_pkg::FRACTION_BITS_D
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_command,
  input  wire logic [bir_pkg::CH_W-1:0]          in_red,
  input  wire logic [bir_pkg::CH_W-1:0]          in_green,
  input  wire logic [bir_pkg::CH_W-1:0]          in_blue,
  input  wire logic [bir_pkg::COORD_W-1:0]       in_dest_x,
  input  wire logic [bir_pkg::COORD_W-1:0]       in_dest_y,
  output logic                                   out_valid,
  output logic [bir_pkg::CH_W-1:0]               out_red,
  output logic [bir_pkg::CH_W-1:0]               out_green,
  output logic [bir_pkg::CH_W-1:0]               out_blue,
  output logic                                   out_bad_coordinate,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bir_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FB     = FRACTION_BITS;
  localparam int SW     = bir_pkg::SRC_W;
  localparam int DW     = bir_pkg::DST_W;
  localparam int PW     = bir_pkg::PIX_W;
  localparam int CW     = bir_pkg::CH_W;
  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int QW     = SW + FB;
  localparam int PRODW  = bir_pkg::COORD_W + SW;
  localparam int NUM_W  = PRODW + FB;
  localparam int ACW    = (AW > 2 * SW + 1) ? AW : 2 * SW + 1;
  localparam int TAG_W  = 2 + PW + AW;

  logic [SW-1:0] src_w_r, src_h_r;
  logic [DW-1:0] dst_w_r, dst_h_r;
  logic [AW-1:0] laddr_r;
  logic          cfg_hit;
  logic          accept;

  logic [SW-1:0] sw, sh;
  logic [DW-1:0] dw, dh;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign cfg_hit = cfg_valid && cfg_ready &&
                   (cfg_index == bir_pkg::REG_SRC_WIDTH  ||
                    cfg_index == bir_pkg::REG_SRC_HEIGHT ||
                    cfg_index == bir_pkg::REG_DST_WIDTH  ||
                    cfg_index == bir_pkg::REG_DST_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= bir_pkg::SRC_SIZE_RST;
      src_h_r <= bir_pkg::SRC_SIZE_RST;
      dst_w_r <= bir_pkg::DST_SIZE_RST;
      dst_h_r <= bir_pkg::DST_SIZE_RST;
      laddr_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bir_pkg::REG_SRC_WIDTH:  src_w_r <= cfg_data[SW-1:0];
          bir_pkg::REG_SRC_HEIGHT: src_h_r <= cfg_data[SW-1:0];
          bir_pkg::REG_DST_WIDTH:  dst_w_r <= cfg_data[DW-1:0];
          bir_pkg::REG_DST_HEIGHT: dst_h_r <= cfg_data[DW-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        laddr_r <= '0;
      end else if (accept && !in_command) begin
        laddr_r <= (laddr_r == AW'(DEPTH - 1)) ? '0 : laddr_r + 1'b1;
      end
    end
  end

  always_comb begin
    sw = (src_w_r == '0) ? SW'(1) :
         (src_w_r > MAX_SRC_WIDTH) ? SW'(MAX_SRC_WIDTH) : src_w_r;
    sh = (src_h_r == '0) ? SW'(1) :
         (src_h_r > MAX_SRC_HEIGHT) ? SW'(MAX_SRC_HEIGHT) : src_h_r;
    dw = (dst_w_r == '0) ? DW'(1) : dst_w_r;
    dh = (dst_h_r == '0) ? DW'(1) : dst_h_r;
  end

  // entry stage: scaled coordinates and range check
  logic             s0_vld_r;
  logic [TAG_W-1:0] s0_tag_r;
  logic [PRODW-1:0] s0_px_r, s0_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
    s0_tag_r <= {in_command,
                 (DW'(in_dest_x) >= dw) || (DW'(in_dest_y) >= dh),
                 in_red, in_green, in_blue, laddr_r};
    s0_px_r  <= PRODW'(in_dest_x) * PRODW'(sw);
    s0_py_r  <= PRODW'(in_dest_y) * PRODW'(sh);
  end

  logic [1:0][NUM_W-1:0] div_num;
  logic [1:0][DW-1:0]    div_den;
  logic                  d_vld;
  logic [TAG_W-1:0]      d_tag;
  logic [1:0][QW-1:0]    d_quo;

  assign div_num[0] = {s0_px_r, {FB{1'b0}}};
  assign div_num[1] = {s0_py_r, {FB{1'b0}}};
  assign div_den[0] = dw;
  assign div_den[1] = dh;

  bir_div #(
    .QW    (QW),
    .NUM_W (NUM_W),
    .DEN_W (DW),
    .TAG_W (TAG_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s0_vld_r),
    .in_tag  (s0_tag_r),
    .num     (div_num),
    .den     (div_den),
    .out_vld (d_vld),
    .out_tag (d_tag),
    .quo     (d_quo)
  );

  // clamp stage
  logic [SW-1:0] xi_c, yi_c, x1_c, y1_c;
  logic [SW-1:0] a_xi_r, a_yi_r, a_x1_r, a_y1_r;
  logic [FB-1:0] a_fx_r, a_fy_r;
  logic          a_vld_r;
  logic [TAG_W-1:0] a_tag_r;

  always_comb begin
    xi_c = (d_quo[0][QW-1:FB] > sw - 1'b1) ? sw - 1'b1 : d_quo[0][QW-1:FB];
    yi_c = (d_quo[1][QW-1:FB] > sh - 1'b1) ? sh - 1'b1 : d_quo[1][QW-1:FB];
    x1_c = ({1'b0, xi_c} + 1'b1 < {1'b0, sw}) ? xi_c + 1'b1 : sw - 1'b1;
    y1_c = ({1'b0, yi_c} + 1'b1 < {1'b0, sh}) ? yi_c + 1'b1 : sh - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= d_vld;
    end
    a_tag_r <= d_tag;
    a_xi_r  <= xi_c;
    a_yi_r  <= yi_c;
    a_x1_r  <= x1_c;
    a_y1_r  <= y1_c;
    a_fx_r  <= d_quo[0][FB-1:0];
    a_fy_r  <= d_quo[1][FB-1:0];
  end

  // address stage; loads write here so they stay ordered with reads
  logic [ACW-1:0]   row0_c, row1_c;
  logic [ACW-1:0]   ad1_c, ad2_c, ad3_c, ad4_c;
  logic [AW-1:0]    b_a1_r, b_a2_r, b_a3_r, b_a4_r;
  logic [AW-1:0]    b_waddr_r;
  bir_pkg::ram_wr_t b_wr_r;
  logic             b_req_r, b_bad_r;
  logic [FB-1:0]    b_fx_r, b_fy_r;

  always_comb begin
    row0_c = ACW'(a_yi_r) * ACW'(sw);
    row1_c = ACW'(a_y1_r) * ACW'(sw);
    ad1_c  = row0_c + ACW'(a_xi_r);
    ad2_c  = row0_c + ACW'(a_x1_r);
    ad3_c  = row1_c + ACW'(a_xi_r);
    ad4_c  = row1_c + ACW'(a_x1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_wr_r.we <= 1'b0;
      b_req_r   <= 1'b0;
    end else begin
      b_wr_r.we <= a_vld_r && !a_tag_r[TAG_W-1];
      b_req_r   <= a_vld_r && a_tag_r[TAG_W-1];
    end
    b_wr_r.wdata <= a_tag_r[AW +: PW];
    b_waddr_r    <= a_tag_r[AW-1:0];
    b_bad_r      <= a_tag_r[TAG_W-2];
    b_a1_r       <= ad1_c[AW-1:0];
    b_a2_r       <= ad2_c[AW-1:0];
    b_a3_r       <= ad3_c[AW-1:0];
    b_a4_r       <= ad4_c[AW-1:0];
    b_fx_r       <= a_fx_r;
    b_fy_r       <= a_fy_r;
  end

  logic [PW-1:0] p1, p2, p3, p4;

  bir_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_top (
    .clk     (clk),
    .wr      (b_wr_r),
    .waddr   (b_waddr_r),
    .raddr_a (b_a1_r),
    .raddr_b (b_a2_r),
    .rdata_a (p1),
    .rdata_b (p2)
  );

  bir_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_bot (
    .clk     (clk),
    .wr      (b_wr_r),
    .waddr   (b_waddr_r),
    .raddr_a (b_a3_r),
    .raddr_b (b_a4_r),
    .rdata_a (p3),
    .rdata_b (p4)
  );

  logic          c_vld_r, c_bad_r;
  logic [FB-1:0] c_fx_r, c_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_req_r;
    end
    c_bad_r <= b_bad_r;
    c_fx_r  <= b_fx_r;
    c_fy_r  <= b_fy_r;
  end

  // channel lanes: red, green, blue
  logic [2:0][CW-1:0] lane_res;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    bir_lane #(.FB(FB)) u_lane (
      .clk (clk),
      .p1  (p1[k*CW +: CW]),
      .p2  (p2[k*CW +: CW]),
      .p3  (p3[k*CW +: CW]),
      .p4  (p4[k*CW +: CW]),
      .fx  (c_fx_r),
      .fy  (c_fy_r),
      .res (lane_res[k])
    );
  end

  logic [2:0] l_vld_r;
  logic [2:0] l_bad_r;
  logic       out_valid_r, out_bad_r;
  logic [CW-1:0] out_red_r, out_green_r, out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_vld_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      l_vld_r     <= {l_vld_r[1:0], c_vld_r};
      out_valid_r <= l_vld_r[2];
    end
    l_bad_r     <= {l_bad_r[1:0], c_bad_r};
    out_bad_r   <= l_bad_r[2];
    out_red_r   <= l_bad_r[2] ? '0 : lane_res[2];
    out_green_r <= l_bad_r[2] ? '0 : lane_res[1];
    out_blue_r  <= l_bad_r[2] ? '0 : lane_res[0];
  end

  assign out_valid          = out_valid_r;
  assign out_bad_coordinate = out_bad_r;
  assign out_red            = out_red_r;
  assign out_green          = out_green_r;
  assign out_blue           = out_blue_r;

endmodule
`default_nettype wire

>>> sv/bir_div.sv
`default_nettype none
module bir_div #(
  parameter int QW    = 25,
  parameter int NUM_W = 37,
  parameter int DEN_W = 13,
  parameter int TAG_W = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_vld,
  input  wire logic [TAG_W-1:0]           in_tag,
  input  wire logic [1:0][NUM_W-1:0]      num,
  input  wire logic [1:0][DEN_W-1:0]      den,
  output logic                            out_vld,
  output logic [TAG_W-1:0]                out_tag,
  output logic [1:0][QW-1:0]              quo
);

  logic [QW-1:0]                  vld_r;
  logic [QW-1:0][TAG_W-1:0]       tag_r;
  logic [QW-1:0][1:0][DEN_W-1:0]  rem_r;
  logic [QW-1:0][1:0][QW-1:0]     q_r;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic                   vld_in;
    logic [TAG_W-1:0]       tag_in;
    logic [1:0][DEN_W-1:0]  rem_in;
    logic [1:0][QW-1:0]     q_in;
    logic [1:0][DEN_W-1:0]  rem_nxt;
    logic [1:0][QW-1:0]     q_nxt;

    if (i == 0) begin : g_first
      always_comb begin
        vld_in = in_vld;
        tag_in = in_tag;
        for (int j = 0; j < 2; j++) begin
          rem_in[j] = DEN_W'(num[j][NUM_W-1:QW]);
          q_in[j]   = num[j][QW-1:0];
        end
      end
    end else begin : g_rest
      assign vld_in = vld_r[i-1];
      assign tag_in = tag_r[i-1];
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
    end

    always_comb begin
      logic [DEN_W:0] t;
      logic [DEN_W:0] diff;
      logic           ge;
      for (int j = 0; j < 2; j++) begin
        t          = {rem_in[j], q_in[j][QW-1]};
        diff       = t - {1'b0, den[j]};
        ge         = (t >= {1'b0, den[j]});
        rem_nxt[j] = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        q_nxt[j]   = {q_in[j][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      tag_r[i] <= tag_in;
      rem_r[i] <= rem_nxt;
      q_r[i]   <= q_nxt;
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_tag = tag_r[QW-1];
  assign quo     = q_r[QW-1];

endmodule
`default_nettype wire

>>> sv/bir_ram.sv
`default_nettype none
module bir_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic                          clk,
  input  wire bir_pkg::ram_wr_t              wr,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [AW-1:0]                 raddr_a,
  input  wire logic [AW-1:0]                 raddr_b,
  output logic [bir_pkg::PIX_W-1:0]          rdata_a,
  output logic [bir_pkg::PIX_W-1:0]          rdata_b
);

  logic [bir_pkg::PIX_W-1:0] mem [DEPTH];
  logic [bir_pkg::PIX_W-1:0] rdata_a_r;
  logic [bir_pkg::PIX_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

>>> sv/bir_lane.sv
`default_nettype none
module bir_lane #(
  parameter int FB = 16
) (
  input  wire logic                        clk,
  input  wire logic [bir_pkg::CH_W-1:0]    p1,
  input  wire logic [bir_pkg::CH_W-1:0]    p2,
  input  wire logic [bir_pkg::CH_W-1:0]    p3,
  input  wire logic [bir_pkg::CH_W-1:0]    p4,
  input  wire logic [FB-1:0]               fx,
  input  wire logic [FB-1:0]               fy,
  output logic [bir_pkg::CH_W-1:0]         res
);

  localparam int HW = bir_pkg::CH_W + FB + 1;
  localparam int VW = HW + FB + 1;
  localparam int RW = VW - 2 * FB;
  localparam logic [FB:0]   ONE  = (FB + 1)'(1) << FB;
  localparam logic [VW-1:0] HALF = VW'(1) << (2 * FB - 1);

  logic [HW-1:0]               h0_r, h0_nxt;
  logic [HW-1:0]               h1_r, h1_nxt;
  logic [FB-1:0]               fy_r;
  logic [VW-1:0]               v_r, v_nxt;
  logic [bir_pkg::CH_W-1:0]    res_r, res_nxt;
  logic [FB:0]                 wx0, wy0;
  logic [VW-1:0]               rounded;
  logic [RW-1:0]               rv;

  always_comb begin
    wx0    = ONE - {1'b0, fx};
    h0_nxt = HW'(p1) * HW'(wx0) + HW'(p2) * HW'(fx);
    h1_nxt = HW'(p3) * HW'(wx0) + HW'(p4) * HW'(fx);
    wy0    = ONE - {1'b0, fy_r};
    v_nxt  = VW'(h0_r) * VW'(wy0) + VW'(h1_r) * VW'(fy_r);
    rounded = v_r + HALF;
    rv      = rounded[VW-1:2*FB];
    res_nxt = (rv > RW'(255)) ? 8'hFF : rv[bir_pkg::CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    h0_r  <= h0_nxt;
    h1_r  <= h1_nxt;
    fy_r  <= fy;
    v_r   <= v_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

>>> dv/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = bir_pkg::FRACTION_BITS_D;
  localparam int STORE_DEPTH = bir_pkg::MAX_SRC_WIDTH_D * bir_pkg::MAX_SRC_HEIGHT_D;
  localparam int CH_W = bir_pkg::CH_W;
  localparam int PIX_W = bir_pkg::PIX_W;
  localparam int COORD_W = bir_pkg::COORD_W;
  localparam int CFG_IDX_W = bir_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = bir_pkg::CFG_DATA_W;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;
  localparam int SETTLE_CYCLES = FB + 24;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            bad;
  } pixel_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic [CH_W-1:0] in_red = '0, in_green = '0, in_blue = '0;
  logic [COORD_W-1:0] in_dest_x = '0, in_dest_y = '0;
  logic out_valid;
  logic [CH_W-1:0] out_red, out_green, out_blue;
  logic out_bad_coordinate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bilinear_image_resize i_dut (.*);

  // scaler state mirror
  logic [PIX_W-1:0] pixel_store [STORE_DEPTH];
  int unsigned load_addr;
  int unsigned src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  pixel_out_t scaled_pixels_due[$];
  int mismatches = 0;
  int items_sent = 0;
  bit burst_mode = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("bilinear_image_resize regression: fail");
    $finish;
  end

  function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] p1, logic [CH_W-1:0] p2,
                                                  logic [CH_W-1:0] p3, logic [CH_W-1:0] p4,
                                                  longint unsigned fx, longint unsigned fy);
    longint unsigned one, sum, r;
    one = 64'd1 << FB;
    sum = 64'(p1) * ((one - fx) * (one - fy)) + 64'(p2) * (fx * (one - fy))
        + 64'(p3) * ((one - fx) * fy) + 64'(p4) * (fx * fy);
    r = (sum + (64'd1 << (2 * FB - 1))) >> (2 * FB);
    return (r > 255) ? 8'hFF : r[CH_W-1:0];
  endfunction

  function automatic pixel_out_t scale_pixel(int unsigned x, int unsigned y);
    pixel_out_t res;
    int unsigned sw, sh, dw, dh, xi, yi, x1, y1;
    longint unsigned px, py, fx, fy;
    logic [PIX_W-1:0] n [4];
    sw = (src_w_reg == 0) ? 1 : (src_w_reg > bir_pkg::MAX_SRC_WIDTH_D) ?
         bir_pkg::MAX_SRC_WIDTH_D : src_w_reg;
    sh = (src_h_reg == 0) ? 1 : (src_h_reg > bir_pkg::MAX_SRC_HEIGHT_D) ?
         bir_pkg::MAX_SRC_HEIGHT_D : src_h_reg;
    dw = (dst_w_reg == 0) ? 1 : dst_w_reg;
    dh = (dst_h_reg == 0) ? 1 : dst_h_reg;
    res = '0;
    if (x >= dw || y >= dh) begin
      res.bad = 1'b1;
      return res;
    end
    px = ((longint'(x) * sw) << FB) / dw;
    py = ((longint'(y) * sh) << FB) / dh;
    fx = px & ((64'd1 << FB) - 1);
    fy = py & ((64'd1 << FB) - 1);
    xi = 32'(px >> FB);
    yi = 32'(py >> FB);
    if (xi > sw - 1) xi = sw - 1;
    if (yi > sh - 1) yi = sh - 1;
    x1 = (xi + 1 < sw) ? xi + 1 : sw - 1;
    y1 = (yi + 1 < sh) ? yi + 1 : sh - 1;
    n[0] = pixel_store[(yi * sw + xi) % STORE_DEPTH];
    n[1] = pixel_store[(yi * sw + x1) % STORE_DEPTH];
    n[2] = pixel_store[(y1 * sw + xi) % STORE_DEPTH];
    n[3] = pixel_store[(y1 * sw + x1) % STORE_DEPTH];
    res.red   = mix_channel(n[0][23:16], n[1][23:16], n[2][23:16], n[3][23:16], fx, fy);
    res.green = mix_channel(n[0][15:8], n[1][15:8], n[2][15:8], n[3][15:8], fx, fy);
    res.blue  = mix_channel(n[0][7:0], n[1][7:0], n[2][7:0], n[3][7:0], fx, fy);
    return res;
  endfunction

  task automatic send_item(logic cmd, logic [PIX_W-1:0] pix,
                           logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    {in_red, in_green, in_blue} <= pix;
    in_dest_x <= x;
    in_dest_y <= y;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (cmd == CMD_LOAD) begin
      pixel_store[load_addr] = pix;
      load_addr = (load_addr + 1) % STORE_DEPTH;
    end else begin
      scaled_pixels_due.push_back(scale_pixel(32'(x), 32'(y)));
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(negedge clk);
    while (scaled_pixels_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      bir_pkg::REG_SRC_WIDTH:  src_w_reg = 32'(val & 13'h1FF);
      bir_pkg::REG_SRC_HEIGHT: src_h_reg = 32'(val & 13'h1FF);
      bir_pkg::REG_DST_WIDTH:  dst_w_reg = 32'(val);
      bir_pkg::REG_DST_HEIGHT: dst_h_reg = 32'(val);
      default: ;
    endcase
    if (idx <= bir_pkg::REG_DST_HEIGHT) load_addr = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh,
                           int unsigned dw, int unsigned dh);
    drain();
    write_reg(bir_pkg::REG_SRC_WIDTH, CFG_DATA_W'(sw));
    write_reg(bir_pkg::REG_SRC_HEIGHT, CFG_DATA_W'(sh));
    write_reg(bir_pkg::REG_DST_WIDTH, CFG_DATA_W'(dw));
    write_reg(bir_pkg::REG_DST_HEIGHT, CFG_DATA_W'(dh));
  endtask

  function automatic int unsigned image_pixels();
    int unsigned sw, sh;
    sw = (src_w_reg == 0) ? 1 : (src_w_reg > bir_pkg::MAX_SRC_WIDTH_D) ?
         bir_pkg::MAX_SRC_WIDTH_D : src_w_reg;
    sh = (src_h_reg == 0) ? 1 : (src_h_reg > bir_pkg::MAX_SRC_HEIGHT_D) ?
         bir_pkg::MAX_SRC_HEIGHT_D : src_h_reg;
    return sw * sh;
  endfunction

  task automatic load_image(bit extremes);
    logic [PIX_W-1:0] pix;
    for (int i = 0; i < image_pixels(); i++) begin
      pix = PIX_W'($urandom);
      if (extremes) pix = (i % 2) ? 24'hFFFFFF : 24'h000000;
      send_item(CMD_LOAD, pix, COORD_W'($urandom), COORD_W'($urandom));
    end
  endtask

  task automatic request(int unsigned x, int unsigned y);
    send_item(CMD_REQUEST, PIX_W'($urandom), x[COORD_W-1:0], y[COORD_W-1:0]);
  endtask

  task automatic test_directed;
    set_sizes(2, 2, 4, 4);
    load_image(1);
    request(0, 0);
    request(1, 1);
    request(3, 3);
    request(3, 0);
    request(4, 0);
    request(0, 4);
    request(4095, 4095);
    set_sizes(2, 2, 0, 0);
    load_image(0);
    request(0, 0);
    request(1, 0);
    request(2048, 2048);
  endtask

  task automatic test_size_extremes;
    set_sizes(256, 1, 4096, 1);
    load_image(0);
    request(4095, 0);
    request(2047, 0);
    request(4096 - 1, 1);
    set_sizes(1, 256, 1, 4096);
    load_image(0);
    request(0, 4095);
    request(0, 1000);
    set_sizes(0, 0, 8191, 3);
    load_image(0);
    request(4095, 2);
    set_sizes(13'h1201, 511, 5, 300);
    load_image(0);
    request(4, 299);
    request(2, 150);
    // unused register index must not restart the load address
    set_sizes(3, 3, 7, 7);
    send_item(CMD_LOAD, PIX_W'($urandom), '0, '0);
    send_item(CMD_LOAD, PIX_W'($urandom), '0, '0);
    drain();
    write_reg(REG_UNUSED, 13'h1FFF);
    for (int i = 2; i < 9; i++) send_item(CMD_LOAD, PIX_W'($urandom), '0, '0);
    for (int i = 0; i < 8; i++) request(i, 7 - i);
  endtask

  task automatic test_random_phases;
    int unsigned sw, sh, dw, dh, n;
    while (items_sent < 1300) begin
      sw = $urandom_range(1, 16);
      sh = $urandom_range(1, 16);
      dw = $urandom_range(1, 64);
      dh = $urandom_range(1, 64);
      case ($urandom_range(0, 7))
        0: dw = 4096;
        1: dh = $urandom_range(2048, 4095);
        2: begin dw = 1; dh = 1; end
        default: ;
      endcase
      set_sizes(sw, sh, dw, dh);
      burst_mode = $urandom_range(0, 2) == 0;
      load_image(0);
      n = $urandom_range(20, 50);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: request($urandom_range(0, 4095), $urandom_range(0, 4095));
          1: send_item(CMD_LOAD, PIX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
          default: request($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
        endcase
      end
      burst_mode = 0;
    end
  endtask

  always @(posedge clk) begin
    pixel_out_t due, seen;
    if (out_valid) begin
      seen = {out_red, out_green, out_blue, out_bad_coordinate};
      if (scaled_pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", seen);
      end else begin
        due = scaled_pixels_due.pop_front();
        if (seen !== due) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: rgb %h/%h/%h bad %b, expected %h/%h/%h bad %b",
                     seen.red, seen.green, seen.blue, seen.bad,
                     due.red, due.green, due.blue, due.bad);
        end
      end
    end
  end

  initial begin
    src_w_reg = 256;
    src_h_reg = 256;
    dst_w_reg = 256;
    dst_h_reg = 256;
    load_addr = 0;
    foreach (pixel_store[i]) pixel_store[i] = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_size_extremes();
    test_random_phases();
    start <= 1'b0;
    for (int i = 0; i < 2000 && scaled_pixels_due.size() != 0; i++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (scaled_pixels_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("bilinear_image_resize regression: pass");
    end else begin
      $display("bilinear_image_resize regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
